// ===== design/pbwd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbwd_pkg: shared types and constants of the bridge window decoder
// Field widths, item kinds, configuration register indexes and the region
// table entry record.
// ----------------------------------------------------------------------------
`default_nettype none

package pbwd_pkg;

    localparam int ADDR_W      = 32;
    localparam int ENTRY_IDX_W = 4;
    localparam int REGION_W    = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_BASE  = 2'd0,
        CFG_WIN_MASK  = 2'd1,
        CFG_WIN_IS_IO = 2'd2
    } t_cfg_idx;

    // One region table entry as written by a load item.
    typedef struct packed {
        logic              enable;
        logic              is_io;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] value;
    } t_region_entry;

    // Table write request and compare strobe handed to the region table.
    typedef struct packed {
        logic                   capture;
        logic                   we;
        logic [ENTRY_IDX_W-1:0] index;
        t_region_entry          entry;
    } t_table_ctrl;

endpackage

`default_nettype wire

// ===== design/pbwd_in_if.sv =====
// ----------------------------------------------------------------------------
// pbwd_in_if: input item channel of the bridge window decoder
// Valid/ready channel carrying one load or lookup item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbwd_in_if;
    import pbwd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   entry_enable;
    logic                   entry_is_io;
    logic [ADDR_W-1:0]      entry_base;
    logic [ADDR_W-1:0]      entry_span;
    logic [ADDR_W-1:0]      entry_match_mask;
    logic [ADDR_W-1:0]      entry_match_value;
    logic [ADDR_W-1:0]      offset;

    modport source (
        output valid, kind, entry_index, entry_enable, entry_is_io, entry_base,
               entry_span, entry_match_mask, entry_match_value, offset,
        input  ready
    );

    modport sink (
        input  valid, kind, entry_index, entry_enable, entry_is_io, entry_base,
               entry_span, entry_match_mask, entry_match_value, offset,
        output ready
    );

endinterface

`default_nettype wire

// ===== design/pbwd_out_if.sv =====
// ----------------------------------------------------------------------------
// pbwd_out_if: result item channel of the bridge window decoder
// Valid/ready channel carrying one decode result.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbwd_out_if;
    import pbwd_pkg::*;

    logic                valid;
    logic                ready;
    logic                hit;
    logic [REGION_W-1:0] region;
    logic [ADDR_W-1:0]   sub_offset;
    logic [ADDR_W-1:0]   pci_address;

    modport source (
        output valid, hit, region, sub_offset, pci_address,
        input  ready
    );

    modport sink (
        input  valid, hit, region, sub_offset, pci_address,
        output ready
    );

endinterface

`default_nettype wire

// ===== design/pbwd_region_table.sv =====
// ----------------------------------------------------------------------------
// pbwd_region_table: region entry storage and parallel address compare
// Holds the region entries, compares every entry against one address and
// registers the claim vector and the per-entry offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module pbwd_region_table #(
    parameter int NUM_REGIONS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pbwd_pkg::t_table_ctrl         i_ctrl,
    input  wire logic                          i_win_is_io,
    input  wire logic [pbwd_pkg::ADDR_W-1:0]   i_addr,
    output logic      [NUM_REGIONS-1:0]        o_match,
    output logic      [pbwd_pkg::ADDR_W-1:0]   o_diff [NUM_REGIONS]
);
    import pbwd_pkg::*;

    // Wide enough to compare the 4-bit load index against any entry number.
    localparam int CMP_W = (NUM_REGIONS > 16) ? $clog2(NUM_REGIONS + 1) : ENTRY_IDX_W + 1;

    logic                r_enable [NUM_REGIONS];
    logic                r_is_io  [NUM_REGIONS];
    logic [ADDR_W-1:0]   r_base   [NUM_REGIONS];
    logic [ADDR_W-1:0]   r_span   [NUM_REGIONS];
    logic [ADDR_W-1:0]   r_mask   [NUM_REGIONS];
    logic [ADDR_W-1:0]   r_value  [NUM_REGIONS];

    logic [NUM_REGIONS-1:0] n_match;
    logic [ADDR_W-1:0]      n_diff [NUM_REGIONS];
    logic [NUM_REGIONS-1:0] w_sel;

    always_comb begin
        for (int i = 0; i < NUM_REGIONS; i++) begin
            w_sel[i] = i_ctrl.we &&
                       (CMP_W'(i_ctrl.index) == CMP_W'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_enable[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < NUM_REGIONS; i++) begin
                if (w_sel[i]) begin
                    r_enable[i] <= i_ctrl.entry.enable;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_REGIONS; i++) begin
            if (w_sel[i]) begin
                r_is_io[i] <= i_ctrl.entry.is_io;
                r_base[i]  <= i_ctrl.entry.base;
                r_span[i]  <= i_ctrl.entry.span;
                r_mask[i]  <= i_ctrl.entry.mask;
                r_value[i] <= i_ctrl.entry.value;
            end
        end
    end

    // Each entry checks space, range and sparse match on its own.
    always_comb begin
        for (int i = 0; i < NUM_REGIONS; i++) begin
            n_diff[i]  = i_addr - r_base[i];
            n_match[i] = r_enable[i] && (r_is_io[i] == i_win_is_io) &&
                         (n_diff[i] < r_span[i]) &&
                         ((i_addr & r_mask[i]) == r_value[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            o_match <= n_match;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                o_diff[i] <= n_diff[i];
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/pci_bridge_window_decode_top.sv =====
// ----------------------------------------------------------------------------
// pci_bridge_window_decode_top: PCI bridge window decoder
// Translates bridge window offsets into PCI addresses and finds the region
// table entry that claims each address.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on i_req, a valid/ready channel. A load item writes one region
// entry; a lookup item forms base + (offset & mask) from the window
// registers and asks every enabled entry of the window's space whether it
// claims that address. The lowest-numbered claiming entry wins. Each item
// yields exactly one result on o_rsp; a load gives an all-zero acknowledge.
// The user must write the window registers (i_cfg_we/i_cfg_idx/i_cfg_wdata)
// only while no item is in flight; the block itself does not enforce this.
// The path has four register stages: input, translated address, per-entry
// claim vector, and result. Throughput is one item per clock while o_rsp
// does not stall.
// Loads update the table as they leave the address stage, so every lookup
// sees exactly the loads accepted before it.
// Reset clears all pipeline valids, every entry's enable flag and the window
// registers (base 0, mask all ones, memory space). When o_rsp stalls, the
// stages fill and i_req.ready falls once the result register and all stages
// hold items; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pci_bridge_window_decode_top #(
    parameter int NUM_REGIONS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pbwd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pbwd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    pbwd_in_if.sink                              i_req,
    pbwd_out_if.source                           o_rsp
);
    import pbwd_pkg::*;

    localparam int IDX_W = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

    // Window registers.
    logic [ADDR_W-1:0] r_win_base;
    logic [ADDR_W-1:0] r_win_mask;
    logic              r_win_is_io;

    // Stage valids.
    logic r_s1_v, r_s2_v, r_s3_v, r_o_v;

    // Stage payloads.
    t_kind                  r_s1_kind, r_s2_kind, r_s3_kind;
    logic [ENTRY_IDX_W-1:0] r_s1_idx, r_s2_idx;
    t_region_entry          r_s1_entry, r_s2_entry;
    logic [ADDR_W-1:0]      r_s1_offset;
    logic [ADDR_W-1:0]      r_s2_addr, r_s3_addr;

    logic                   r_o_hit;
    logic [REGION_W-1:0]    r_o_region;
    logic [ADDR_W-1:0]      r_o_sub;
    logic [ADDR_W-1:0]      r_o_addr;

    // Stage flow control.
    logic free_o, free_s3, free_s2, free_s1;
    logic mv_s1, mv_s2, mv_s3, acc;

    t_table_ctrl            w_ctrl;
    logic [NUM_REGIONS-1:0] w_match;
    logic [ADDR_W-1:0]      w_diff [NUM_REGIONS];

    logic                   n_hit;
    logic [IDX_W-1:0]       n_sel;
    logic [ADDR_W-1:0]      n_sub;

    assign free_o  = !r_o_v || o_rsp.ready;
    assign mv_s3   = r_s3_v && free_o;
    assign free_s3 = !r_s3_v || free_o;
    assign mv_s2   = r_s2_v && free_s3;
    assign free_s2 = !r_s2_v || free_s3;
    assign mv_s1   = r_s1_v && free_s2;
    assign free_s1 = !r_s1_v || free_s2;

    assign i_req.ready = free_s1;
    assign acc         = i_req.valid && free_s1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_base  <= '0;
            r_win_mask  <= '1;
            r_win_is_io <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIN_BASE:  r_win_base  <= i_cfg_wdata[ADDR_W-1:0];
                CFG_WIN_MASK:  r_win_mask  <= i_cfg_wdata[ADDR_W-1:0];
                CFG_WIN_IS_IO: r_win_is_io <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (free_s1) begin
                r_s1_v <= i_req.valid;
            end
            if (free_s2) begin
                r_s2_v <= mv_s1;
            end
            if (free_s3) begin
                r_s3_v <= mv_s2;
            end
            if (free_o) begin
                r_o_v <= mv_s3;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_kind         <= t_kind'(i_req.kind);
            r_s1_idx          <= i_req.entry_index;
            r_s1_entry.enable <= i_req.entry_enable;
            r_s1_entry.is_io  <= i_req.entry_is_io;
            r_s1_entry.base   <= i_req.entry_base;
            r_s1_entry.span   <= i_req.entry_span;
            r_s1_entry.mask   <= i_req.entry_match_mask;
            r_s1_entry.value  <= i_req.entry_match_value;
            r_s1_offset       <= i_req.offset;
        end
    end

    // Address translation stage.
    always_ff @(posedge i_clk) begin
        if (mv_s1) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_idx   <= r_s1_idx;
            r_s2_entry <= r_s1_entry;
            r_s2_addr  <= r_win_base + (r_s1_offset & r_win_mask);
        end
    end

    // The table is written by a load as it leaves the address stage, and the
    // claim vector of a lookup is captured at the same point.
    always_comb begin
        w_ctrl.capture = mv_s2;
        w_ctrl.we      = mv_s2 && (r_s2_kind == KIND_LOAD);
        w_ctrl.index   = r_s2_idx;
        w_ctrl.entry   = r_s2_entry;
    end

    pbwd_region_table #(
        .NUM_REGIONS (NUM_REGIONS)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_win_is_io (r_win_is_io),
        .i_addr      (r_s2_addr),
        .o_match     (w_match),
        .o_diff      (w_diff)
    );

    always_ff @(posedge i_clk) begin
        if (mv_s2) begin
            r_s3_kind <= r_s2_kind;
            r_s3_addr <= r_s2_addr;
        end
    end

    // Priority pick: scanning downward leaves the lowest claiming entry.
    always_comb begin
        n_hit = 1'b0;
        n_sel = '0;
        n_sub = '0;
        for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                n_hit = 1'b1;
                n_sel = IDX_W'(i);
                n_sub = w_diff[i];
            end
        end
    end

    // Result register. A load gives an all-zero acknowledge.
    always_ff @(posedge i_clk) begin
        if (mv_s3) begin
            if (r_s3_kind == KIND_LOOKUP) begin
                r_o_hit    <= n_hit;
                r_o_region <= REGION_W'(n_sel);
                r_o_sub    <= n_sub;
                r_o_addr   <= r_s3_addr;
            end else begin
                r_o_hit    <= 1'b0;
                r_o_region <= '0;
                r_o_sub    <= '0;
                r_o_addr   <= '0;
            end
        end
    end

    assign o_rsp.valid       = r_o_v;
    assign o_rsp.hit         = r_o_hit;
    assign o_rsp.region      = r_o_region;
    assign o_rsp.sub_offset  = r_o_sub;
    assign o_rsp.pci_address = r_o_addr;

endmodule

`default_nettype wire
